[rtl/dwst_pkg.sv]
`timescale 1ns / 1ps
package dwst_pkg;

    localparam int WQ       = 30;
    localparam int TAN_FRAC = 20;

    localparam logic [30:0] ONE_Q     = 31'h4000_0000;
    localparam logic [29:0] HALF_Q    = 30'h2000_0000;
    localparam logic [30:0] TAN_EPS   = 31'd1074;
    localparam logic [40:0] TAN_MAX   = 41'h0FF_FFFF_FFFF;
    localparam logic [16:0] MORPH_ONE = 17'h1_0000;

    // long division lanes: dividend, divisor and quotient widths
    localparam int NUM_W = 72;
    localparam int DEN_W = 31;
    localparam int QUO_W = 41;

    // square root: radicand bits and one result bit per step
    localparam int RAD_W      = 62;
    localparam int ROOT_STEPS = 31;

    typedef enum logic [1:0] {
        CMD_SINCOS = 2'd0,
        CMD_TAN    = 2'd1,
        CMD_MORPH  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [1:0] quad;
    } tag_t;

    // warp coefficients, index 0 is the linear term
    localparam logic [5:0][30:0] COEF_ORIG = {
        31'd1631031862, 31'd348983513, 31'd735677973,
        31'd680769380,  31'd693714077, 31'd843314857
    };
    localparam logic [5:0][30:0] COEF_REFIT = {
        31'd1623632097, 31'd359145787, 31'd731518172,
        31'd681472951,  31'd693665320, 31'd843314857
    };

    function automatic logic [30:0] clamp_unit(input logic signed [32:0] x);
        logic [30:0] r;
        if (x < 0)
        begin
            r = '0;
        end
        else if (x > $signed({2'b00, ONE_Q}))
        begin
            r = ONE_Q;
        end
        else
        begin
            r = x[30:0];
        end
        return r;
    endfunction

endpackage

[rtl/dwst_warp.sv]
`timescale 1ns / 1ps
module dwst_warp
    import dwst_pkg::*;
#(
    parameter int ANGLE_BITS = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        warp_tier,
    input  logic        in_valid,
    input  cmd_t        in_cmd,
    input  logic [31:0] in_angle,
    input  logic [16:0] in_morph,
    output logic        out_valid,
    output tag_t        out_tag,
    output logic [30:0] out_w
);

    localparam int FB     = ANGLE_BITS - 2;
    localparam int HSTEPS = 5;
    localparam int NST    = 11;

    typedef struct packed {
        tag_t        tag;
        logic [29:0] t;
        logic [16:0] m;
        logic [29:0] av;
        logic        vneg;
        logic [28:0] v2;
    } ctx_t;

    logic [NST-1:0] vld_reg;

    // input stage
    logic [29:0] t_in;
    logic [29:0] av_in;
    logic [16:0] m_in;
    ctx_t        ctx0_reg;

    assign t_in  = 30'(in_angle[FB-1:0]) << (WQ - FB);
    assign av_in = t_in[29] ? (t_in - HALF_Q) : (HALF_Q - t_in);
    assign m_in  = (in_morph > MORPH_ONE) ? MORPH_ONE : in_morph;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx0_reg.tag.cmd  <= in_cmd;
            ctx0_reg.tag.quad <= in_angle[ANGLE_BITS-1 -: 2];
            ctx0_reg.t        <= t_in;
            ctx0_reg.m        <= m_in;
            ctx0_reg.av       <= av_in;
            ctx0_reg.vneg     <= ~t_in[29];
            ctx0_reg.v2       <= '0;
        end
    end

    // v^2 and Horner chain, one multiply per stage
    ctx_t        hctx_reg [0:HSTEPS];
    logic [30:0] hp_reg   [0:HSTEPS];
    logic [59:0] sq0;

    assign sq0 = 60'(ctx0_reg.av) * 60'(ctx0_reg.av);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hctx_reg[0] <= '{tag: ctx0_reg.tag, t: ctx0_reg.t, m: ctx0_reg.m,
                             av: ctx0_reg.av, vneg: ctx0_reg.vneg, v2: sq0[58:30]};
            hp_reg[0]   <= warp_tier ? COEF_REFIT[HSTEPS] : COEF_ORIG[HSTEPS];
        end
    end

    for (genvar k = 1; k <= HSTEPS; k++)
    begin : g_horner
        logic [59:0] hprod;
        assign hprod = 60'(hctx_reg[k-1].v2) * 60'(hp_reg[k-1]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hctx_reg[k] <= hctx_reg[k-1];
                hp_reg[k]   <= 31'(hprod[59:30])
                             + (warp_tier ? COEF_REFIT[HSTEPS-k] : COEF_ORIG[HSTEPS-k]);
            end
        end
    end

    // odd term
    ctx_t        ctx7_reg;
    logic [60:0] prod7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx7_reg  <= hctx_reg[HSTEPS];
            prod7_reg <= 61'(hctx_reg[HSTEPS].av) * 61'(hp_reg[HSTEPS]);
        end
    end

    // round magnitude, apply sign around one half, clamp
    logic [61:0]        rnd8;
    logic [30:0]        mag8;
    logic signed [32:0] ws8;
    ctx_t               ctx8_reg;
    logic [30:0]        w8_reg;

    assign rnd8 = 62'(prod7_reg) + (62'(1) << (WQ - 1));
    assign mag8 = rnd8[60:30];
    assign ws8  = ctx7_reg.vneg ? ($signed({3'b000, HALF_Q}) - $signed({2'b00, mag8}))
                                : ($signed({3'b000, HALF_Q}) + $signed({2'b00, mag8}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx8_reg <= ctx7_reg;
            w8_reg   <= clamp_unit(ws8);
        end
    end

    // morph difference times M
    logic signed [32:0] d9;
    logic [30:0]        ad9;
    ctx_t               ctx9_reg;
    logic [30:0]        w9_reg;
    logic [47:0]        mp9_reg;
    logic               dneg9_reg;

    assign d9  = $signed({2'b00, w8_reg}) - $signed({3'b000, ctx8_reg.t});
    assign ad9 = (d9 < 0) ? 31'(-d9) : d9[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx9_reg  <= ctx8_reg;
            w9_reg    <= w8_reg;
            mp9_reg   <= 48'(ad9) * 48'(ctx8_reg.m);
            dneg9_reg <= d9 < 0;
        end
    end

    // blend, select and reflect in odd quadrants
    logic [48:0]        adj_r;
    logic [30:0]        adj;
    logic signed [32:0] wm;
    logic [30:0]        wsel;
    tag_t               tag10_reg;
    logic [30:0]        w10_reg;

    assign adj_r = 49'(mp9_reg) + 49'(16'h8000);
    assign adj   = adj_r[46:16];
    assign wm    = dneg9_reg ? ($signed({3'b000, ctx9_reg.t}) - $signed({2'b00, adj}))
                             : ($signed({3'b000, ctx9_reg.t}) + $signed({2'b00, adj}));
    assign wsel  = (ctx9_reg.tag.cmd == CMD_MORPH) ? clamp_unit(wm) : w9_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag10_reg <= ctx9_reg.tag;
            w10_reg   <= ctx9_reg.tag.quad[0] ? (ONE_Q - wsel) : wsel;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_tag   = tag10_reg;
    assign out_w     = w10_reg;

endmodule

[rtl/dwst_isqrt.sv]
`timescale 1ns / 1ps
module dwst_isqrt
    import dwst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  tag_t        in_tag,
    input  logic [30:0] in_w,
    output logic        out_valid,
    output tag_t        out_tag,
    output logic [30:0] out_w,
    output logic [30:0] out_omw,
    output logic [30:0] out_root
);

    localparam int NST = ROOT_STEPS + 2;

    typedef struct packed {
        tag_t        tag;
        logic [30:0] w;
        logic [30:0] omw;
    } ctx_t;

    logic [NST-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // squares of both legs
    logic [30:0] omw_in;
    ctx_t        ctxq_reg;
    logic [61:0] sa_reg;
    logic [61:0] sb_reg;

    assign omw_in = ONE_Q - in_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctxq_reg <= '{tag: in_tag, w: in_w, omw: omw_in};
            sa_reg   <= 62'(omw_in) * 62'(omw_in);
            sb_reg   <= 62'(in_w) * 62'(in_w);
        end
    end

    // digit-by-digit root, one result bit per stage
    ctx_t        ctx_reg  [0:ROOT_STEPS];
    logic [61:0] x_reg    [0:ROOT_STEPS];
    logic [32:0] rem_reg  [0:ROOT_STEPS];
    logic [30:0] root_reg [0:ROOT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0]  <= ctxq_reg;
            x_reg[0]    <= sa_reg + sb_reg;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= ROOT_STEPS; k++)
    begin : g_root
        logic [34:0] r2;
        logic [34:0] trial;
        logic [34:0] diff;
        logic        ge;
        assign r2    = {rem_reg[k-1], x_reg[k-1][RAD_W-1 -: 2]};
        assign trial = {2'b00, root_reg[k-1], 2'b01};
        assign diff  = r2 - trial;
        assign ge    = r2 >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctx_reg[k]  <= ctx_reg[k-1];
                x_reg[k]    <= x_reg[k-1] << 2;
                rem_reg[k]  <= ge ? diff[32:0] : r2[32:0];
                root_reg[k] <= {root_reg[k-1][29:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_tag   = ctx_reg[ROOT_STEPS].tag;
    assign out_w     = ctx_reg[ROOT_STEPS].w;
    assign out_omw   = ctx_reg[ROOT_STEPS].omw;
    assign out_root  = root_reg[ROOT_STEPS];

endmodule

[rtl/dwst_div.sv]
`timescale 1ns / 1ps
module dwst_div
    import dwst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  tag_t             in_tag,
    input  logic [NUM_W-1:0] in_num_a,
    input  logic [DEN_W-1:0] in_den_a,
    input  logic [NUM_W-1:0] in_num_b,
    input  logic [DEN_W-1:0] in_den_b,
    output logic             out_valid,
    output tag_t             out_tag,
    output logic [QUO_W-1:0] out_quo_a,
    output logic [QUO_W-1:0] out_quo_b
);

    localparam int NST = QUO_W + 1;

    // quotient bits shift in from the bottom as dividend bits leave the top
    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] bits;
    } lane_t;

    function automatic lane_t div_step(input lane_t l);
        lane_t        r;
        logic [DEN_W:0] r2;
        logic           ge;
        r2     = {l.rem, l.bits[QUO_W-1]};
        ge     = r2 >= {1'b0, l.den};
        r.den  = l.den;
        r.rem  = ge ? DEN_W'(r2 - {1'b0, l.den}) : r2[DEN_W-1:0];
        r.bits = {l.bits[QUO_W-2:0], ge};
        return r;
    endfunction

    logic [NST-1:0] vld_reg;
    tag_t           tag_reg [0:QUO_W];
    lane_t          a_reg   [0:QUO_W];
    lane_t          b_reg   [0:QUO_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= in_tag;
            a_reg[0]   <= '{den: in_den_a, rem: in_num_a[NUM_W-1 -: DEN_W],
                            bits: in_num_a[QUO_W-1:0]};
            b_reg[0]   <= '{den: in_den_b, rem: in_num_b[NUM_W-1 -: DEN_W],
                            bits: in_num_b[QUO_W-1:0]};
        end
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= tag_reg[k-1];
                a_reg[k]   <= div_step(a_reg[k-1]);
                b_reg[k]   <= div_step(b_reg[k-1]);
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_tag   = tag_reg[QUO_W];
    assign out_quo_a = a_reg[QUO_W].bits;
    assign out_quo_b = b_reg[QUO_W].bits;

endmodule

[rtl/diagonal_warp_sincos_tan.sv]
`timescale 1ns / 1ps
// Diagonal-warp sine/cosine/tangent pipeline.
// Input channel: in_valid/in_stall with command, angle (quarter turns, top two
// bits are the quadrant) and morph. Output channel: out_valid/out_stall with
// sin_value, cos_value (Q1.TRIG_FRAC_BITS) and tan_value (Q20.20); fields the
// command does not produce are zero. Configuration: cfg_valid/cfg_ready with
// cfg_warp_tier; cfg_ready is always high. Write it only while the pipe is empty.
// Throughput: one item per clock while no result is stalled. From the accepting
// edge to the result register there are 87 register stages in all: the 11-stage
// warp polynomial, the 33-stage square root (one root bit per digit stage), the
// 42-stage dual divider (one quotient bit per step stage) and the output register.
// A stalled result holds the whole pipeline: in_stall follows out_stall while
// a result is waiting, and nothing is dropped or repeated.
// Reset clears every valid bit and sets warp_tier to 1 (refit coefficients).
module diagonal_warp_sincos_tan
    import dwst_pkg::*;
#(
    parameter int ANGLE_BITS     = 32,
    parameter int TRIG_FRAC_BITS = 30
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_warp_tier,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [31:0]        angle,
    input  logic [16:0]        morph,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sin_value,
    output logic signed [31:0] cos_value,
    output logic signed [40:0] tan_value
);

    logic warp_tier_reg;
    logic en;
    logic out_valid_reg;

    assign cfg_ready = 1'b1;
    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warp_tier_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            warp_tier_reg <= cfg_warp_tier;
        end
    end

    logic        wp_valid;
    tag_t        wp_tag;
    logic [30:0] wp_w;

    dwst_warp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_warp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .warp_tier (warp_tier_reg),
        .in_valid  (in_valid),
        .in_cmd    (cmd_t'(command)),
        .in_angle  (angle),
        .in_morph  (morph),
        .out_valid (wp_valid),
        .out_tag   (wp_tag),
        .out_w     (wp_w)
    );

    logic        sq_valid;
    tag_t        sq_tag;
    logic [30:0] sq_w;
    logic [30:0] sq_omw;
    logic [30:0] sq_root;

    dwst_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (wp_valid),
        .in_tag    (wp_tag),
        .in_w      (wp_w),
        .out_valid (sq_valid),
        .out_tag   (sq_tag),
        .out_w     (sq_w),
        .out_omw   (sq_omw),
        .out_root  (sq_root)
    );

    // lane A divides w by the norm or by the tangent denominator, lane B gives cosine
    logic [30:0]      s1;
    logic [30:0]      den;
    logic [NUM_W-1:0] num_trig;
    logic [NUM_W-1:0] num_tan;
    logic [NUM_W-1:0] num_cos;
    logic             is_tan;

    assign s1       = (sq_root == '0) ? 31'd1 : sq_root;
    assign den      = (sq_omw < TAN_EPS) ? TAN_EPS : sq_omw;
    assign num_trig = (NUM_W'(sq_w) << TRIG_FRAC_BITS) + NUM_W'(s1 >> 1);
    assign num_tan  = (NUM_W'(sq_w) << TAN_FRAC) + NUM_W'(den >> 1);
    assign num_cos  = (NUM_W'(sq_omw) << TRIG_FRAC_BITS) + NUM_W'(s1 >> 1);
    assign is_tan   = sq_tag.cmd == CMD_TAN;

    logic             dv_valid;
    tag_t             dv_tag;
    logic [QUO_W-1:0] dv_qa;
    logic [QUO_W-1:0] dv_qb;

    dwst_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_num_a  (is_tan ? num_tan : num_trig),
        .in_den_a  (is_tan ? den : s1),
        .in_num_b  (num_cos),
        .in_den_b  (s1),
        .out_valid (dv_valid),
        .out_tag   (dv_tag),
        .out_quo_a (dv_qa),
        .out_quo_b (dv_qb)
    );

    // clamp, apply quadrant signs, zero the fields not asked for
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] sn;
    logic [QUO_W-1:0] cs;
    logic [QUO_W-1:0] tn;
    logic [31:0]      sin_next;
    logic [31:0]      cos_next;
    logic [40:0]      tan_next;
    logic [31:0]      sin_reg;
    logic [31:0]      cos_reg;
    logic [40:0]      tan_reg;

    assign lim = QUO_W'(1) << TRIG_FRAC_BITS;
    assign sn  = (dv_qa > lim) ? lim : dv_qa;
    assign cs  = (dv_qb > lim) ? lim : dv_qb;
    assign tn  = (dv_qa > TAN_MAX) ? TAN_MAX : dv_qa;

    always_comb
    begin
        sin_next = '0;
        cos_next = '0;
        tan_next = '0;
        unique case (dv_tag.cmd)
            CMD_SINCOS, CMD_MORPH:
            begin
                sin_next = dv_tag.quad[1] ? 32'(QUO_W'(0) - sn) : 32'(sn);
                cos_next = (dv_tag.quad[1] ^ dv_tag.quad[0]) ? 32'(QUO_W'(0) - cs)
                                                             : 32'(cs);
            end
            CMD_TAN:
            begin
                tan_next = dv_tag.quad[0] ? (QUO_W'(0) - tn) : tn;
            end
            CMD_NONE:
            begin
                tan_next = '0;
            end
            default:
            begin
                tan_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
            tan_reg <= tan_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_value = $signed(sin_reg);
    assign cos_value = $signed(cos_reg);
    assign tan_value = $signed(tan_reg);

endmodule

[rtl/dwst_checker.sv]
`timescale 1ns / 1ps
module dwst_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] sin_value,
    input logic signed [31:0] cos_value,
    input logic signed [40:0] tan_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sin_value)
            && $stable(cos_value) && $stable(tan_value))
        else $error("stalled result changed");

    // input backpressure only comes from a waiting result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // tangent results carry no sine or cosine
    a_tan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tan_value != 41'sd0 |-> sin_value == 32'sd0 && cos_value == 32'sd0)
        else $error("tangent and sine/cosine both present");

    // sine and cosine stay on the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sin_value <= 32'sd1073741824 && sin_value >= -32'sd1073741824
            && cos_value <= 32'sd1073741824 && cos_value >= -32'sd1073741824)
        else $error("sine or cosine out of range");

endmodule

bind diagonal_warp_sincos_tan dwst_checker u_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import dwst_pkg::*;

    typedef struct {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
        logic signed [40:0] tan_v;
    } trig_t;

    class trig_scoreboard;
        trig_t    pending[$];
        bit       tier = 1'b1;
        int       errors = 0;

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        function longint clamp01(longint x);
            if (x < 0)
                return 0;
            if (x > (64'd1 << 30))
                return 64'd1 << 30;
            return x;
        endfunction

        function longint scale_unit(longint num, longint s);
            longint r;
            r = ((num << 30) + (s >> 1)) / s;
            if (r > (64'd1 << 30))
                r = 64'd1 << 30;
            return r;
        endfunction

        function void note_angle(logic [1:0] cmd_bits, logic [31:0] ang, logic [16:0] m_in);
            cmd_t    cmd;
            trig_t   e;
            logic [1:0] quad;
            longint  one, t, v, av, v2, p, mag, w, d, ad, adj, m, den, r, omw, s, sn, cs;
            one = 64'd1 << 30;
            cmd = cmd_t'(cmd_bits);
            quad = ang[31:30];
            t = ang[29:0];
            e.sin_v = '0;
            e.cos_v = '0;
            e.tan_v = '0;
            if (cmd != CMD_NONE)
            begin
                v = t - (one >> 1);
                av = (v < 0) ? -v : v;
                v2 = (av * av) >> 30;
                p = tier ? COEF_REFIT[5] : COEF_ORIG[5];
                for (int i = 4; i >= 0; i--)
                    p = ((v2 * p) >> 30) + (tier ? COEF_REFIT[i] : COEF_ORIG[i]);
                mag = (av * p + (64'd1 << 29)) >> 30;
                w = clamp01((one >> 1) + ((v < 0) ? -mag : mag));
                if (cmd == CMD_MORPH)
                begin
                    d = w - t;
                    ad = (d < 0) ? -d : d;
                    m = (m_in > MORPH_ONE) ? MORPH_ONE : m_in;
                    adj = (ad * m + (64'd1 << 15)) >> 16;
                    w = clamp01(t + ((d < 0) ? -adj : adj));
                end
                if (quad[0])
                    w = one - w;
                if (cmd == CMD_TAN)
                begin
                    den = one - w;
                    if (den < TAN_EPS)
                        den = TAN_EPS;
                    r = ((w << 20) + (den >> 1)) / den;
                    if (r > TAN_MAX)
                        r = TAN_MAX;
                    e.tan_v = quad[0] ? -r : r;
                end
                else
                begin
                    omw = one - w;
                    s = int_sqrt(omw * omw + w * w);
                    if (s == 0)
                        s = 1;
                    sn = scale_unit(w, s);
                    cs = scale_unit(omw, s);
                    if (quad == 2 || quad == 3)
                        sn = -sn;
                    if (quad == 1 || quad == 2)
                        cs = -cs;
                    e.sin_v = sn;
                    e.cos_v = cs;
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [31:0] sv, logic signed [31:0] cv,
                                   logic signed [40:0] tv);
            trig_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result sin=%0d cos=%0d tan=%0d", $time, sv, cv, tv);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sv !== e.sin_v)
            begin
                $display("%0t: sin_value expected %0d actual %0d", $time, e.sin_v, sv);
                errors++;
            end
            if (cv !== e.cos_v)
            begin
                $display("%0t: cos_value expected %0d actual %0d", $time, e.cos_v, cv);
                errors++;
            end
            if (tv !== e.tan_v)
            begin
                $display("%0t: tan_value expected %0d actual %0d", $time, e.tan_v, tv);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_warp_tier = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         command = '0;
    logic [31:0]        angle = '0;
    logic [16:0]        morph = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] sin_value;
    logic signed [31:0] cos_value;
    logic signed [40:0] tan_value;

    trig_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit long_hold = 1'b0;

    diagonal_warp_sincos_tan u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_warp_tier(cfg_warp_tier),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .angle(angle), .morph(morph),
        .out_valid(out_valid), .out_stall(out_stall),
        .sin_value(sin_value), .cos_value(cos_value), .tan_value(tan_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // result side: check transfers, stall in random bursts or one long hold
    initial
    begin
        int burst;
        int hold_cnt;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sb.check_result(sin_value, cos_value, tan_value);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                hold_cnt = 300;
                while (hold_cnt > 0)
                begin
                    @(posedge clk);
                    hold_cnt--;
                end
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end
            else if (burst > 0)
            begin
                burst--;
                out_stall <= (burst != 0);
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 8);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_angle(logic [1:0] c, logic [31:0] a, logic [16:0] m);
        int gap;
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= c;
        angle    <= a;
        morph    <= m;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_angle(c, a, m);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_tier(bit val);
        drain_pipe();
        cfg_valid     <= 1'b1;
        cfg_warp_tier <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.tier = val;
    endtask

    task automatic directed_set();
        logic [31:0] edges[8] = '{32'h0, 32'h3FFF_FFFF, 32'h4000_0000, 32'h8000_0000,
                                  32'hC000_0000, 32'hFFFF_FFFF, 32'h2000_0000, 32'h7FFF_FFFF};
        foreach (edges[i])
            send_angle(CMD_SINCOS, edges[i], 17'h0);
        send_angle(CMD_TAN, 32'h3FFF_FFFF, 17'h0);
        send_angle(CMD_TAN, 32'h4000_0000, 17'h0);
        send_angle(CMD_TAN, 32'h0, 17'h1FFFF);
        send_angle(CMD_TAN, 32'hBFFF_FFFF, 17'h0);
        send_angle(CMD_TAN, 32'hE000_0000, 17'h0);
        send_angle(CMD_MORPH, 32'h1234_5678, 17'h0);
        send_angle(CMD_MORPH, 32'h1234_5678, MORPH_ONE);
        send_angle(CMD_MORPH, 32'h9234_5678, 17'h1FFFF);
        send_angle(CMD_MORPH, 32'hF000_0001, 17'h8000);
        send_angle(CMD_NONE, 32'h5555_5555, 17'h1FFFF);
        send_angle(CMD_NONE, 32'hFFFF_FFFF, 17'h0);
    endtask

    task automatic random_run(int n);
        logic [16:0] m;
        for (int i = 0; i < n; i++)
        begin
            m = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
            send_angle(2'($urandom_range(0, 3)), $urandom, m);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_set();
        write_tier(1'b0);
        directed_set();
        random_run(250);
        write_tier(1'b1);
        long_hold = 1'b1;
        random_run(250);
        write_tier(1'b0);
        random_run(100);
        drain_pipe();
        idle_on = 1'b0;
        random_run(150);
        drain_pipe();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
